### rtl/lsw_pkg.sv
`default_nettype none

package lsw_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int WORD_W  = 24;
    localparam int WCODE_W = 2;
    localparam int PAD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int HELD_W  = 4;
    localparam int GROUP_W = 3;

    // held count once a 9-bit word has left a whole byte behind
    localparam logic [HELD_W-1:0] HELD_FULL = 4'd8;

    typedef enum logic [WCODE_W-1:0] {
        WC_8   = 2'd0,
        WC_16  = 2'd1,
        WC_24  = 2'd2,
        WC_BAD = 2'd3
    } width_code_t;

    typedef enum logic [1:0] {
        JOB_ERR,
        JOB_FOUR,
        JOB_THREE
    } job_kind_t;

    typedef struct packed {
        job_kind_t           kind;
        logic [WORD_W-1:0]   data_word;
        logic [WCODE_W-1:0]  width_code;
        logic                dc;
        logic [PAD_W-1:0]    lead_pad;
        logic                last;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ERR,
        B_FOUR,
        B_PAD,
        B_HI,
        B_LO,
        B_FILL,
        B_FLUSH
    } back_state_t;

endpackage

`default_nettype wire

### rtl/lsw_front.sv
`default_nettype none

module lsw_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [lsw_pkg::WORD_W-1:0]  data_word,
    input  wire logic [lsw_pkg::WCODE_W-1:0] width_code,
    input  wire logic                        dc,
    input  wire logic [lsw_pkg::PAD_W-1:0]   lead_pad,
    input  wire logic                        last,
    input  wire logic                        q_full,
    output logic                             q_push,
    output lsw_pkg::job_t                    q_job
);
    import lsw_pkg::*;

    logic three_wire_reg;
    logic bad_width;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            three_wire_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            three_wire_reg <= cfg_wdata;
        end
    end

    // 24-bit words have no 9-bit form
    assign bad_width = (width_code == WC_BAD) || (three_wire_reg && width_code == WC_24);

    always_comb
    begin
        q_job.data_word  = data_word;
        q_job.width_code = width_code;
        q_job.dc         = dc;
        q_job.lead_pad   = lead_pad;
        q_job.last       = last;
        priority if (bad_width)
        begin
            q_job.kind = JOB_ERR;
        end
        else if (three_wire_reg)
        begin
            q_job.kind = JOB_THREE;
        end
        else
        begin
            q_job.kind = JOB_FOUR;
        end
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

### rtl/lsw_queue.sv
`default_nettype none

module lsw_queue #(
    parameter int DEPTH = lsw_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire lsw_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               pop_valid,
    output lsw_pkg::job_t      pop_job
);
    import lsw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign pop_valid = (count_reg != '0);
    assign pop_job   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### rtl/lsw_back.sv
`default_nettype none

module lsw_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    input  wire lsw_pkg::job_t              q_job,
    output logic                            q_pop,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [lsw_pkg::BYTE_W-1:0]      out_byte,
    output logic                            dc_level,
    output logic                            end_of_run,
    output logic                            width_error
);
    import lsw_pkg::*;

    back_state_t          state_reg, state_next;
    logic [WORD_W-1:0]    data_reg, data_next;
    logic                 dc_reg, dc_next;
    logic [PAD_W-1:0]     pad_reg, pad_next;
    logic                 last_reg, last_next;
    logic                 wide_reg, wide_next;
    logic [WCODE_W-1:0]   idx_reg, idx_next;
    logic [BYTE_W-1:0]    acc_reg, acc_next;
    logic [HELD_W-1:0]    held_reg, held_next;
    logic [GROUP_W-1:0]   wig_reg, wig_next;

    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic                 dc_level_reg, dc_level_next;
    logic                 end_reg, end_next;
    logic                 err_reg, err_next;

    logic                 out_free;
    logic                 emit;
    logic [8:0]           w9;
    logic [16:0]          combined;
    logic [16:0]          shifted;
    logic [HELD_W-1:0]    held_inc;
    logic [GROUP_W-1:0]   wig_inc;
    logic                 final_word;
    logic [BYTE_W-1:0]    four_byte;

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = (state_reg != B_IDLE);

    // next 9-bit word and the byte it completes
    always_comb
    begin
        unique case (state_reg)
            B_HI:    w9 = {dc_reg, data_reg[15:8]};
            B_LO:    w9 = {dc_reg, data_reg[7:0]};
            default: w9 = '0;
        endcase
        combined = {acc_reg, w9};
        shifted  = combined >> ({1'b0, held_reg[2:0]} + 4'd1);
        held_inc = {1'b0, held_reg[2:0]} + 4'd1;
        wig_inc  = wig_reg + 3'd1;
    end

    always_comb
    begin
        unique case (idx_reg)
            2'd2:    four_byte = data_reg[23:16];
            2'd1:    four_byte = data_reg[15:8];
            default: four_byte = data_reg[7:0];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        data_next  = data_reg;
        dc_next    = dc_reg;
        pad_next   = pad_reg;
        last_next  = last_reg;
        wide_next  = wide_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        held_next  = held_reg;
        wig_next   = wig_reg;
        out_byte_next = '0;
        dc_level_next = 1'b0;
        end_next      = 1'b0;
        err_next      = 1'b0;
        final_word    = 1'b0;
        q_pop         = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    data_next = q_job.data_word;
                    dc_next   = q_job.dc;
                    pad_next  = q_job.lead_pad;
                    last_next = q_job.last;
                    wide_next = (q_job.width_code == WC_16);
                    idx_next  = q_job.width_code;
                    unique case (q_job.kind)
                        JOB_FOUR:  state_next = B_FOUR;
                        JOB_THREE:
                        begin
                            priority if (q_job.lead_pad != '0)
                            begin
                                state_next = B_PAD;
                            end
                            else if (q_job.width_code == WC_16)
                            begin
                                state_next = B_HI;
                            end
                            else
                            begin
                                state_next = B_LO;
                            end
                        end
                        default:   state_next = B_ERR;
                    endcase
                end
            end
            B_ERR:
            begin
                end_next = 1'b1;
                err_next = 1'b1;
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            B_FOUR:
            begin
                out_byte_next = four_byte;
                dc_level_next = dc_reg;
                end_next      = (idx_reg == '0);
                if (out_free)
                begin
                    idx_next = idx_reg - 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_FLUSH:
            begin
                out_byte_next = acc_reg;
                end_next      = 1'b1;
                if (out_free)
                begin
                    held_next  = '0;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                // 3-wire packing: B_PAD, B_HI, B_LO, B_FILL
                if (held_reg == HELD_FULL)
                begin
                    out_byte_next = acc_reg;
                    if (out_free)
                    begin
                        held_next = '0;
                    end
                end
                else
                begin
                    out_byte_next = shifted[7:0];
                    unique case (state_reg)
                        B_LO:    final_word = !last_reg || (wig_inc == '0);
                        B_FILL:  final_word = (wig_inc == '0);
                        default: final_word = 1'b0;
                    endcase
                    end_next = final_word && (held_inc != HELD_FULL);
                    if (out_free)
                    begin
                        acc_next  = combined[7:0];
                        held_next = held_inc;
                        wig_next  = wig_inc;
                        unique case (state_reg)
                            B_PAD:
                            begin
                                pad_next = pad_reg - 1'b1;
                                if (pad_reg == 3'd1)
                                begin
                                    state_next = wide_reg ? B_HI : B_LO;
                                end
                            end
                            B_HI:    state_next = B_LO;
                            default: state_next = B_FILL;
                        endcase
                        if (final_word)
                        begin
                            state_next = (held_inc == HELD_FULL) ? B_FLUSH : B_IDLE;
                        end
                    end
                end
            end
        endcase

        out_valid_next = out_free ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            acc_reg       <= '0;
            held_reg      <= '0;
            wig_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            wig_reg       <= wig_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        dc_reg   <= dc_next;
        pad_reg  <= pad_next;
        last_reg <= last_next;
        wide_reg <= wide_next;
        idx_reg  <= idx_next;
        if (out_free)
        begin
            out_byte_reg <= out_byte_next;
            dc_level_reg <= dc_level_next;
            end_reg      <= end_next;
            err_reg      <= err_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign dc_level    = dc_level_reg;
    assign end_of_run  = end_reg;
    assign width_error = err_reg;

endmodule

`default_nettype wire

### rtl/lcd_spi_word_formatter.sv
// Display word to SPI byte formatter.
// Input channel (in_valid / in_stall): one request carries data_word, width_code,
// dc, lead_pad and last. Output channel (out_valid / out_stall): one SPI byte per
// transfer with dc_level, end_of_run (last byte of an input) and width_error.
// cfg_we / cfg_wdata write the three_wire mode bit; write it only while idle.
// 4-wire: 1 to 3 bytes, MSB first. 3-wire: 9-bit words packed eight to nine
// bytes, with lead_pad no-op words and zero fill of the group on last.
// Unsupported widths give a single error result and leave packing untouched.
// The first byte passes the queue slot, the sequencer state register and the
// output register. Throughput: the back end sends one byte per cycle while
// out_stall is low, and takes a load step from the queue before each item in
// which it sends no byte. A queue of QUEUE_DEPTH items sits between the
// input stage and the byte sequencer, so inputs keep being taken while bytes drain.
// When out_stall is high the output register holds its byte and the sequencer
// waits; in_stall rises once the queue is full.
// Reset clears mode (4-wire), packing state, queue and output valid.
`default_nettype none

module lcd_spi_word_formatter #(
    parameter int QUEUE_DEPTH = lsw_pkg::QUEUE_DEPTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [lsw_pkg::WORD_W-1:0]  data_word,
    input  wire logic [lsw_pkg::WCODE_W-1:0] width_code,
    input  wire logic                        dc,
    input  wire logic [lsw_pkg::PAD_W-1:0]   lead_pad,
    input  wire logic                        last,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [lsw_pkg::BYTE_W-1:0]       out_byte,
    output logic                             dc_level,
    output logic                             end_of_run,
    output logic                             width_error
);
    import lsw_pkg::*;

    job_t push_job;
    job_t pop_job;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;

    lsw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_word  (data_word),
        .width_code (width_code),
        .dc         (dc),
        .lead_pad   (lead_pad),
        .last       (last),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    lsw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_job   (pop_job)
    );

    lsw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_job       (pop_job),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .dc_level    (dc_level),
        .end_of_run  (end_of_run),
        .width_error (width_error)
    );

endmodule

`default_nettype wire

### dv/lcd_spi_word_formatter_tb.sv
module lcd_spi_word_formatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsw_pkg::*;

    localparam bit MODE_FOUR  = 1'b0;
    localparam bit MODE_THREE = 1'b1;

    localparam int HOLD_CYCLES   = 150;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASES        = 5;
    localparam int PHASE_WORDS   = 17;
    localparam int DIRECTED_ROWS = 25;
    localparam int PRINT_CAP     = 60;

    typedef struct packed {
        logic [WORD_W-1:0] data;
        width_code_t       wcode;
        bit                dcv;
        bit [PAD_W-1:0]    pad;
        bit                lastv;
    } word_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] val;
        logic              dcl;
        logic              fin;
        logic              err;
    } spi_result_t;

    // n_typed = 0: results come from the packing predictor
    typedef struct packed {
        bit                mode;
        logic [WORD_W-1:0] data;
        width_code_t       wcode;
        bit                dcv;
        bit [PAD_W-1:0]    pad;
        bit                lastv;
        bit [1:0]          n_typed;
        logic [7:0]        b0;
        logic [7:0]        b1;
        logic [7:0]        b2;
        bit                dcl;
        bit                err;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_wdata = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [WORD_W-1:0]   data_word = '0;
    logic [WCODE_W-1:0]  width_code = '0;
    logic                dc = 1'b0;
    logic [PAD_W-1:0]    lead_pad = '0;
    logic                last = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [BYTE_W-1:0]   out_byte;
    logic                dc_level;
    logic                end_of_run;
    logic                width_error;

    lcd_spi_word_formatter u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_word  (data_word),
        .width_code (width_code),
        .dc         (dc),
        .lead_pad   (lead_pad),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .dc_level   (dc_level),
        .end_of_run (end_of_run),
        .width_error(width_error)
    );

    // packer mirror
    bit                mode_three = MODE_FOUR;
    logic [15:0]       pk_acc = '0;
    int unsigned       pk_held = 0;
    logic [GROUP_W-1:0] pk_words = '0;

    spi_result_t bytes_due [$];
    spi_result_t burst [$];

    int  n_mismatch = 0;
    bit  hold_long = 1'b0;
    bit  calm = 1'b0;

    dir_row_t plan [DIRECTED_ROWS] = '{
        '{MODE_FOUR,  24'h000000, WC_8,   1'b0, 3'd0, 1'b0, 2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{MODE_FOUR,  24'hFFFFFF, WC_8,   1'b1, 3'd0, 1'b0, 2'd1, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b0},
        '{MODE_FOUR,  24'h00ABCD, WC_16,  1'b1, 3'd0, 1'b0, 2'd2, 8'hAB, 8'hCD, 8'h00, 1'b1, 1'b0},
        '{MODE_FOUR,  24'hFFFFFF, WC_24,  1'b0, 3'd7, 1'b1, 2'd3, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0},
        '{MODE_FOUR,  24'h123456, WC_24,  1'b1, 3'd0, 1'b0, 2'd3, 8'h12, 8'h34, 8'h56, 1'b1, 1'b0},
        '{MODE_FOUR,  24'hFFFFFF, WC_BAD, 1'b1, 3'd7, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1},
        '{MODE_FOUR,  24'h5A0F3C, WC_16,  1'b0, 3'd3, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        // first 3-wire word: 1_1010_0101 leaves one bit behind
        '{MODE_THREE, 24'h0000A5, WC_8,   1'b1, 3'd0, 1'b0, 2'd1, 8'hD2, 8'h00, 8'h00, 1'b0, 1'b0},
        '{MODE_THREE, 24'hFFFFFF, WC_16,  1'b1, 3'd0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{MODE_THREE, 24'h00FFFF, WC_24,  1'b1, 3'd0, 1'b0, 2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1},
        '{MODE_THREE, 24'hFFFFFF, WC_BAD, 1'b1, 3'd7, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1},
        '{MODE_THREE, 24'h000000, WC_8,   1'b0, 3'd7, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{MODE_THREE, 24'h0000FF, WC_8,   1'b1, 3'd3, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        // eight words from a fresh group, last on the eighth: no fill
        '{MODE_THREE, 24'h000011, WC_8,   1'b1, 3'd0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{MODE_THREE, 24'h000022, WC_8,   1'b0, 3'd0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{MODE_THREE, 24'h000044, WC_8,   1'b1, 3'd0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{MODE_THREE, 24'h000088, WC_8,   1'b0, 3'd0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{MODE_THREE, 24'h000055, WC_8,   1'b1, 3'd0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{MODE_THREE, 24'h0000AA, WC_8,   1'b0, 3'd0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{MODE_THREE, 24'h0000F0, WC_8,   1'b1, 3'd0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{MODE_THREE, 24'h00000F, WC_8,   1'b1, 3'd0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{MODE_THREE, 24'h0000C3, WC_8,   1'b0, 3'd0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        // 4-wire in mid group leaves the packer alone
        '{MODE_FOUR,  24'h00FF00, WC_16,  1'b0, 3'd5, 1'b1, 2'd2, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0},
        '{MODE_THREE, 24'h0000FF, WC_8,   1'b1, 3'd0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{MODE_THREE, 24'h000000, WC_16,  1'b0, 3'd0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}
    };

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        if (n_mismatch < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, what);
        n_mismatch++;
    endtask

    function automatic void push_nine(input logic [8:0] w9);
        logic [15:0] acc;
        int unsigned h;
        h = (pk_held & 7) + 9;
        acc = {pk_acc[6:0], w9};
        while (h >= 8)
        begin
            burst.push_back('{val: BYTE_W'(acc >> (h - 8)), dcl: 1'b0, fin: 1'b0, err: 1'b0});
            h -= 8;
        end
        pk_acc = acc & ((16'd1 << h) - 16'd1);
        pk_held = h;
        pk_words = pk_words + 1'b1;
    endfunction

    // SPI bytes caused by one word request, built into burst
    function automatic void format_word(input word_req_t r);
        int nb;
        burst.delete();
        if (r.wcode == WC_BAD || (mode_three && r.wcode == WC_24))
        begin
            burst.push_back('{val: 8'h00, dcl: 1'b0, fin: 1'b1, err: 1'b1});
            return;
        end
        if (!mode_three)
        begin
            nb = int'(r.wcode) + 1;
            for (int i = nb; i > 0; i--)
                burst.push_back('{val: r.data[(i-1)*8 +: 8], dcl: r.dcv, fin: i == 1,
                                  err: 1'b0});
            return;
        end
        for (int i = 0; i < int'(r.pad); i++)
            push_nine(9'h000);
        if (r.wcode == WC_16)
        begin
            push_nine({r.dcv, r.data[15:8]});
            push_nine({r.dcv, r.data[7:0]});
        end
        else
        begin
            push_nine({r.dcv, r.data[7:0]});
        end
        if (r.lastv)
        begin
            while (pk_words != 0)
                push_nine(9'h000);
        end
        burst[burst.size()-1].fin = 1'b1;
    endfunction

    function automatic word_req_t rand_word();
        word_req_t r;
        int pick;
        r.data = WORD_W'($urandom);
        pick = $urandom_range(0, 99);
        if (mode_three)
            r.wcode = pick < 45 ? WC_8 : pick < 85 ? WC_16 : pick < 93 ? WC_24 : WC_BAD;
        else
            r.wcode = pick < 31 ? WC_8 : pick < 62 ? WC_16 : pick < 93 ? WC_24 : WC_BAD;
        r.dcv = 1'($urandom_range(0, 1));
        r.pad = $urandom_range(0, 9) < 6 ? 3'd0 : PAD_W'($urandom_range(0, 7));
        r.lastv = $urandom_range(0, 4) == 0;
        return r;
    endfunction

    // Offer one request and wait for it to be taken; predicted bytes are queued
    // unless the caller types them in.
    task automatic send_word(input word_req_t r, input bit use_model);
        if (!calm && !hold_long && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_word  <= r.data;
        width_code <= r.wcode;
        dc         <= r.dcv;
        lead_pad   <= r.pad;
        last       <= r.lastv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        format_word(r);
        if (use_model)
            foreach (burst[k])
                bytes_due.push_back(burst[k]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_mode(input bit m);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mode_three = m;
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin : out_side
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                out_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                out_stall <= 1'b0;
                hold_long = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : byte_check
        spi_result_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (bytes_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h", out_byte));
            end
            else
            begin
                due = bytes_due.pop_front();
                if (out_byte !== due.val)
                    report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, due.val));
                if (dc_level !== due.dcl)
                    report_mismatch($sformatf("dc_level %b, want %b", dc_level, due.dcl));
                if (end_of_run !== due.fin)
                    report_mismatch($sformatf("end_of_run %b, want %b", end_of_run, due.fin));
                if (width_error !== due.err)
                    report_mismatch($sformatf("width_error %b, want %b", width_error, due.err));
            end
        end
    end

    initial
    begin : watchdog
        int unsigned n_cycles;
        n_cycles = 0;
        while (n_cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            n_cycles++;
        end
        $display("lcd_spi_word_formatter verification failed");
        $finish;
    end

    initial
    begin : stimulus
        word_req_t r;
        dir_row_t row;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[j])
        begin
            row = plan[j];
            if (row.mode != mode_three)
                set_mode(row.mode);
            r = '{data: row.data, wcode: row.wcode, dcv: row.dcv, pad: row.pad,
                  lastv: row.lastv};
            send_word(r, row.n_typed == 0);
            for (int k = 0; k < int'(row.n_typed); k++)
                bytes_due.push_back('{val: k == 0 ? row.b0 : k == 1 ? row.b1 : row.b2,
                                      dcl: row.dcl, fin: k == int'(row.n_typed) - 1,
                                      err: row.err});
        end

        // phases alternate 3-wire / 4-wire; long hold-off in the middle, quiet at the end
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (bit'(ph % 2 == 0) != mode_three)
                set_mode(ph % 2 == 0);
            if (ph == 2)
                hold_long = 1'b1;
            if (ph == PHASES - 1)
                calm = 1'b1;
            for (int i = 0; i < PHASE_WORDS; i++)
                send_word(rand_word(), 1'b1);
        end

        drain();
        repeat (10) @(posedge clk);
        if (n_mismatch == 0)
            $display("lcd_spi_word_formatter verification clean");
        else
            $display("lcd_spi_word_formatter verification failed");
        $finish;
    end

endmodule

### files.f
rtl/lsw_pkg.sv
rtl/lsw_front.sv
rtl/lsw_queue.sv
rtl/lsw_back.sv
rtl/lcd_spi_word_formatter.sv
dv/lcd_spi_word_formatter_tb.sv
